FILE: design/dstq_pkg.sv
// ----------------------------------------------------------------------------
// dstq_pkg
// Shared types, codes and helper functions of the deadline-sorted timer queue.
// ----------------------------------------------------------------------------
package dstq_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int TP_W           = 32;

  localparam logic [62:0] MAX63 = '1;

  // operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_INT   = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  // event-timer device commands
  localparam logic [1:0] DEV_NONE     = 2'd0;
  localparam logic [1:0] DEV_PERIODIC = 2'd1;
  localparam logic [1:0] DEV_ONESHOT  = 2'd2;
  localparam logic [1:0] DEV_STOP     = 2'd3;

  // configuration register indexes
  localparam logic REG_BOOT_CPU    = 1'b0;
  localparam logic REG_TICK_PERIOD = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  timer_id;
    logic [47:0] duration;
    logic        periodic;
    logic        every_tick;
    logic [62:0] now;
  } request_t;

  typedef struct packed {
    logic        result_kind;
    logic [3:0]  fired_timer;
    logic [62:0] remaining;
    logic [1:0]  device_command;
    logic [62:0] device_delay;
    logic        last;
  } result_t;

  typedef enum logic [1:0] {
    JOB_START,
    JOB_STOP,
    JOB_INT,
    JOB_BAD
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [3:0]  timer_id;
    logic [47:0] duration;
    logic        periodic;
    logic        every_tick;
    logic [62:0] now;
  } job_t;

  typedef struct packed {
    logic per;
    logic tick;
    logic act;
  } mode_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_RM_SCAN,
    S_ST_RD,
    S_ST_CMP,
    S_WRITE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_RP_RD,
    S_RP_CMP,
    S_TICK_EMIT,
    S_DUE_RD,
    S_DUE_CMP,
    S_RQ_NEXT,
    S_RQ_CALC,
    S_FINAL
  } back_state_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // time from now to a deadline, floored at zero and clipped to 63 bits
  function automatic logic [62:0] time_left(input logic [63:0] dl, input logic [62:0] now);
    logic [63:0] d;
    d = dl - {1'b0, now};
    if (dl <= {1'b0, now}) return '0;
    return d[63] ? MAX63 : d[62:0];
  endfunction

endpackage

FILE: design/dstq_ram.sv
// ----------------------------------------------------------------------------
// dstq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dstq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/dstq_front.sv
// ----------------------------------------------------------------------------
// dstq_front
// Accepts items, classifies them and holds them in a two-entry job queue.
// ----------------------------------------------------------------------------
module dstq_front import dstq_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     job_valid,
  output job_t     job,
  input  logic     job_pop
);

  job_t       fifo [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  job_t       job_in;

  assign busy = (count == 2'd2);
  assign push = start && !busy;

  always_comb begin
    job_in.timer_id   = request.timer_id;
    job_in.duration   = request.duration;
    job_in.periodic   = request.periodic;
    job_in.every_tick = request.every_tick;
    job_in.now        = request.now;
    case (request.op)
      OP_START: job_in.kind = JOB_START;
      OP_STOP:  job_in.kind = JOB_STOP;
      OP_INT:   job_in.kind = JOB_INT;
      default:  job_in.kind = JOB_BAD;
    endcase
    if (request.op != OP_INT && int'(request.timer_id) >= NUM_TIMERS) begin
      job_in.kind = JOB_BAD;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (job_pop) rptr <= !rptr;
      count <= count + {1'b0, push} - {1'b0, job_pop};
    end
  end

  assign job_valid = (count != 2'd0);
  assign job       = fifo[rptr];

endmodule

FILE: design/dstq_back.sv
// ----------------------------------------------------------------------------
// dstq_back
// Sequencer that runs start, stop and interrupt jobs on the timer stores; other jobs only complete.
// ----------------------------------------------------------------------------
module dstq_back import dstq_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  input  job_t            job,
  output logic            job_pop,
  input  logic            boot_cpu,
  input  logic [TP_W-1:0] tick_ns,
  output result_t         result,
  output logic            result_strobe
);

  localparam int IW = $clog2(NUM_TIMERS);
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam logic [CW-1:0] FULL = CW'(NUM_TIMERS);
  localparam logic [CW-1:0] ONE  = CW'(1);

  back_state_t state, state_next;
  job_t        cur;
  logic [IW-1:0] idx;
  logic [CW-1:0] i;
  logic          rm_tick;
  logic          any_fired;
  logic [63:0]   dl_new;
  logic [IW-1:0] ins_id;
  logic [1:0]    cmd_r;
  logic [62:0]   delay_r;
  logic [62:0]   rem_r;
  logic [IW-1:0] qorder [NUM_TIMERS];
  logic [IW-1:0] torder [NUM_TIMERS];
  logic [IW-1:0] due    [NUM_TIMERS];
  logic [CW-1:0] qcount;
  logic [CW-1:0] tcount;
  logic [CW-1:0] dcount;
  mode_t         mode   [NUM_TIMERS];
  logic          dl_seen [NUM_TIMERS];
  logic          rd_seen;

  result_t result_next;
  logic    strobe_next;

  // store ports
  logic          dl_we;
  logic [IW-1:0] dl_waddr;
  logic [63:0]   dl_wdata;
  logic [IW-1:0] dl_raddr;
  logic [63:0]   dl_rdata;
  logic          per_we;
  logic [47:0]   per_rdata;

  // helpers
  mode_t         cur_mode;
  logic [CW-1:0] list_cnt;
  logic [IW-1:0] list_ent;
  logic          rm_hit;
  logic          rm_end;
  logic [63:0]   dl_rd;
  logic [63:0]   now64;
  logic [63:0]   dur_eff;
  logic [63:0]   dl_start;
  logic [63:0]   dl_rq;
  logic [CW-1:0] tcount_inc;
  logic          is_due;

  assign cur_mode   = mode[idx];
  assign list_cnt   = rm_tick ? tcount : qcount;
  assign list_ent   = rm_tick ? torder[i[IW-1:0]] : qorder[i[IW-1:0]];
  assign rm_end     = (i >= list_cnt);
  assign rm_hit     = !rm_end && (list_ent == idx);
  assign dl_rd      = rd_seen ? dl_rdata : '0;
  assign now64      = {1'b0, cur.now};
  assign dur_eff    = cur.every_tick ? 64'(tick_ns) : 64'(cur.duration);
  assign dl_start   = sat_add(now64, dur_eff);
  assign dl_rq      = sat_add(now64, 64'(per_rdata));
  assign tcount_inc = (tcount < FULL) ? tcount + ONE : tcount;
  assign is_due     = (dl_rd <= now64);
  assign job_pop    = (state == S_IDLE) && job_valid;

  always_comb begin
    case (state)
      S_ST_RD:  dl_raddr = idx;
      S_INS_RD: dl_raddr = qorder[i[IW-1:0]];
      default:  dl_raddr = qorder[0];
    endcase
    dl_we    = (state == S_WRITE && !cur.every_tick) || (state == S_WRITE) ||
               (state == S_RQ_CALC);
    dl_waddr = (state == S_RQ_CALC) ? due[0] : idx;
    dl_wdata = (state == S_RQ_CALC) ? dl_rq : dl_start;
    per_we   = (state == S_WRITE);
  end

  dstq_ram #(.WIDTH(64), .DEPTH(NUM_TIMERS)) u_deadline (
    .clk  (clk),
    .we   (dl_we),
    .waddr(dl_waddr),
    .wdata(dl_wdata),
    .raddr(dl_raddr),
    .rdata(dl_rdata)
  );

  dstq_ram #(.WIDTH(48), .DEPTH(NUM_TIMERS)) u_period (
    .clk  (clk),
    .we   (per_we),
    .waddr(idx),
    .wdata(dur_eff[47:0]),
    .raddr(due[0]),
    .rdata(per_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (job_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (cur.kind)
          JOB_START: state_next = cur_mode.act ? S_RM_SCAN : S_WRITE;
          JOB_STOP:  state_next = S_ST_RD;
          JOB_INT:   state_next = (tcount != '0) ? S_TICK_EMIT : S_DUE_RD;
          default:   state_next = S_FINAL;
        endcase
      end
      S_RM_SCAN: begin
        if (rm_hit || rm_end) begin
          if (cur.kind == JOB_START) begin
            state_next = S_WRITE;
          end else if (rm_tick || (rm_hit && i == '0)) begin
            state_next = S_RP_RD;
          end else begin
            state_next = S_FINAL;
          end
        end
      end
      S_ST_RD:  state_next = S_ST_CMP;
      S_ST_CMP: state_next = cur_mode.act ? S_RM_SCAN : S_FINAL;
      S_WRITE: begin
        if (cur.every_tick) state_next = S_FINAL;
        else if (qcount >= FULL) state_next = S_RP_RD;
        else state_next = S_INS_RD;
      end
      S_INS_RD:  state_next = (i >= qcount) ? S_INS_PUT : S_INS_CMP;
      S_INS_CMP: state_next = (dl_rd < dl_new) ? S_INS_RD : S_INS_PUT;
      S_INS_PUT: state_next = (cur.kind == JOB_START) ? S_RP_RD : S_RQ_NEXT;
      S_RP_RD: begin
        if (boot_cpu || tcount != '0 || qcount == '0) state_next = S_FINAL;
        else state_next = S_RP_CMP;
      end
      S_RP_CMP: state_next = S_FINAL;
      S_TICK_EMIT: begin
        if (i == tcount - ONE) state_next = S_DUE_RD;
      end
      S_DUE_RD:  state_next = (qcount == '0) ? S_RQ_NEXT : S_DUE_CMP;
      S_DUE_CMP: state_next = is_due ? S_DUE_RD : S_RQ_NEXT;
      S_RQ_NEXT: begin
        if (dcount == '0) state_next = any_fired ? S_RP_RD : S_FINAL;
        else if (mode[due[0]].per) state_next = S_RQ_CALC;
      end
      S_RQ_CALC: state_next = (qcount >= FULL) ? S_RQ_NEXT : S_INS_RD;
      S_FINAL:   state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // result outputs
  always_comb begin
    result_next = '0;
    strobe_next = 1'b0;
    case (state)
      S_TICK_EMIT: begin
        strobe_next             = 1'b1;
        result_next.fired_timer = 4'(torder[i[IW-1:0]]);
      end
      S_DUE_CMP: begin
        strobe_next             = is_due;
        result_next.fired_timer = 4'(qorder[0]);
      end
      S_FINAL: begin
        strobe_next                = 1'b1;
        result_next.result_kind    = 1'b1;
        result_next.remaining      = rem_r;
        result_next.device_command = cmd_r;
        result_next.device_delay   = delay_r;
        result_next.last           = 1'b1;
      end
      default: begin
        strobe_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    result  <= result_next;
    rd_seen <= dl_seen[dl_raddr];
    case (state)
      S_IDLE: begin
        if (job_valid) begin
          cur     <= job;
          idx     <= IW'(job.timer_id);
          i       <= '0;
          cmd_r   <= DEV_NONE;
          delay_r <= '0;
          rem_r   <= '0;
        end
      end
      S_DISPATCH: begin
        rm_tick <= cur_mode.tick;
        i       <= '0;
      end
      S_RM_SCAN: begin
        if (!rm_hit && !rm_end) i <= i + ONE;
        if (rm_hit) begin
          for (int j = 0; j < NUM_TIMERS; j++) begin
            if (CW'(j) >= i && CW'(j) + ONE < list_cnt) begin
              if (rm_tick) torder[j] <= torder[(j + 1 < NUM_TIMERS) ? j + 1 : j];
              else         qorder[j] <= qorder[(j + 1 < NUM_TIMERS) ? j + 1 : j];
            end
          end
        end
      end
      S_ST_CMP: begin
        rem_r   <= time_left(dl_rd, cur.now);
        rm_tick <= cur_mode.tick;
        i       <= '0;
      end
      S_WRITE: begin
        if (cur.every_tick) begin
          if (tcount < FULL) torder[tcount[IW-1:0]] <= idx;
          cmd_r <= (!boot_cpu && tcount_inc == ONE) ? DEV_PERIODIC : DEV_NONE;
        end else begin
          dl_new <= dl_start;
          ins_id <= idx;
          i      <= '0;
        end
      end
      S_INS_CMP: begin
        if (dl_rd < dl_new) i <= i + ONE;
      end
      S_INS_PUT: begin
        for (int j = 0; j < NUM_TIMERS; j++) begin
          if (CW'(j) == i) begin
            qorder[j] <= ins_id;
          end else if (CW'(j) > i && CW'(j) <= qcount) begin
            qorder[j] <= qorder[(j > 0) ? j - 1 : j];
          end
        end
      end
      S_RP_RD: begin
        if (boot_cpu || tcount != '0) cmd_r <= DEV_NONE;
        else if (qcount == '0) cmd_r <= DEV_STOP;
      end
      S_RP_CMP: begin
        cmd_r   <= DEV_ONESHOT;
        delay_r <= time_left(dl_rd, cur.now);
      end
      S_TICK_EMIT: begin
        i <= i + ONE;
      end
      S_DUE_CMP: begin
        if (is_due) begin
          due[dcount[IW-1:0]] <= qorder[0];
          for (int j = 0; j + 1 < NUM_TIMERS; j++) begin
            qorder[j] <= qorder[j + 1];
          end
        end
      end
      S_RQ_NEXT: begin
        if (dcount != '0 && !mode[due[0]].per) begin
          for (int j = 0; j + 1 < NUM_TIMERS; j++) begin
            due[j] <= due[j + 1];
          end
        end
      end
      S_RQ_CALC: begin
        dl_new <= dl_rq;
        ins_id <= due[0];
        i      <= '0;
        for (int j = 0; j + 1 < NUM_TIMERS; j++) begin
          due[j] <= due[j + 1];
        end
      end
      default: begin
        i <= i;
      end
    endcase
  end

  // control state: state, counts, mode bits, written marks, fired flag, strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      qcount        <= '0;
      tcount        <= '0;
      dcount        <= '0;
      any_fired     <= 1'b0;
      result_strobe <= 1'b0;
      for (int j = 0; j < NUM_TIMERS; j++) begin
        mode[j]    <= '0;
        dl_seen[j] <= 1'b0;
      end
    end else begin
      state         <= state_next;
      result_strobe <= strobe_next;
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            dcount    <= '0;
            any_fired <= 1'b0;
          end
        end
        S_RM_SCAN: begin
          if (rm_hit) begin
            if (rm_tick) tcount <= tcount - ONE;
            else         qcount <= qcount - ONE;
          end
        end
        S_ST_CMP: begin
          if (cur_mode.act) mode[idx].act <= 1'b0;
        end
        S_WRITE: begin
          mode[idx]    <= '{per: cur.periodic | cur.every_tick, tick: cur.every_tick,
                            act: 1'b1};
          dl_seen[idx] <= 1'b1;
          if (cur.every_tick) tcount <= tcount_inc;
        end
        S_INS_PUT: begin
          qcount <= qcount + ONE;
        end
        S_DUE_CMP: begin
          if (is_due) begin
            qcount    <= qcount - ONE;
            dcount    <= dcount + ONE;
            any_fired <= 1'b1;
          end
        end
        S_RQ_NEXT: begin
          if (dcount != '0 && !mode[due[0]].per) begin
            mode[due[0]].act <= 1'b0;
            dcount           <= dcount - ONE;
          end
        end
        S_RQ_CALC: begin
          dcount <= dcount - ONE;
        end
        default: begin
          qcount <= qcount;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    qcount <= FULL && tcount <= FULL && dcount <= FULL)
    else $error("timer list count above capacity");

  a_last_is_final: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.last |-> result.result_kind)
    else $error("last result is not a completion");

  a_fire_clean: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !result.result_kind |->
      result.device_command == DEV_NONE && !result.last && result.remaining == '0)
    else $error("fire result carries completion fields");

  a_pop_dispatch: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> state == S_DISPATCH)
    else $error("popped job not dispatched");
`endif

endmodule

FILE: design/deadline_sorted_timer_queue_top.sv
// ----------------------------------------------------------------------------
// deadline_sorted_timer_queue_top
// Numbered software timers kept in a deadline-sorted queue plus a tick list.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy rises only while
// the two-entry job queue is full. Each item yields one or more results, each
// shown for exactly one cycle with result_strobe high; the receiver cannot
// stall, so it must take every result on the cycle it appears. The last
// result of an item is the completion (result_kind 1, last 1) carrying the
// event-timer device command. Cost per item is set by the sequencer walking
// the queue through the deadline RAM (registered read), a read state and a
// compare state per entry. The completion is registered onto the ports. The
// cost of a start grows with the queued timers ahead of it and with the list
// entries scanned before a restarted timer; that of a stop of an active timer
// with the entries scanned before it; that of an interrupt with the tick-list
// timers, the fired timers and the queue walked for each re-queued one.
// Configuration writes are always ready and should only be issued while the
// block is idle.
// ----------------------------------------------------------------------------
module deadline_sorted_timer_queue_top import dstq_pkg::*; #(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  // item channel
  input  logic            start,
  output logic            busy,
  input  request_t        request,
  // result channel
  output logic            result_strobe,
  output result_t         result,
  // configuration channel
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [TP_W-1:0] cfg_data
);

  logic            boot_cpu;
  logic [TP_W-1:0] tick_ns;
  logic            job_valid;
  logic            job_pop;
  job_t            job;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      boot_cpu <= 1'b0;
      tick_ns  <= TP_W'(1000000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BOOT_CPU:    boot_cpu <= cfg_data[0];
        REG_TICK_PERIOD: tick_ns  <= cfg_data;
        default:         boot_cpu <= boot_cpu;
      endcase
    end
  end

  // front: accept, classify, queue jobs
  dstq_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .request  (request),
    .busy     (busy),
    .job_valid(job_valid),
    .job      (job),
    .job_pop  (job_pop)
  );

  // back: run jobs on the timer stores
  dstq_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .job          (job),
    .job_pop      (job_pop),
    .boot_cpu     (boot_cpu),
    .tick_ns      (tick_ns),
    .result       (result),
    .result_strobe(result_strobe)
  );

endmodule

FILE: tb/deadline_sorted_timer_queue_top_tb.sv
// ----------------------------------------------------------------------------
// deadline_sorted_timer_queue_top_tb
// Self-checking bench for the deadline-sorted timer queue.
// ----------------------------------------------------------------------------
// A driver pulls items from a pending queue and presents them at the falling
// edge. A monitor at the rising edge sees each accepted item, runs it through
// a local timer-queue predictor and queues the results it should produce.
// Every strobed result is checked field by field against the oldest of them.
// The run goes through several register settings and sender idle rates;
// registers are only written once the block has drained.
// ----------------------------------------------------------------------------
module deadline_sorted_timer_queue_top_tb;
  import dstq_pkg::*;

  localparam int NT          = 16;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_WAIT  = 40;
  localparam logic [62:0] TOP63 = {63{1'b1}};

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            busy;
  request_t        request = '0;
  logic            result_strobe;
  result_t         result;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic            cfg_index = REG_BOOT_CPU;
  logic [TP_W-1:0] cfg_data = '0;

  deadline_sorted_timer_queue_top uut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .request(request),
    .result_strobe(result_strobe), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the timers, both lists and registers.
  // --------------------------------------------------------------------------
  logic        mdl_boot_cpu;
  logic [31:0] mdl_tick_ns;
  logic [63:0] tmr_deadline [NT];
  logic [47:0] tmr_period   [NT];
  logic        tmr_per      [NT];
  logic        tmr_tick     [NT];
  logic        tmr_act      [NT];
  logic [3:0]  sorted_ids   [NT];
  int          sorted_cnt;
  logic [3:0]  tick_ids     [NT];
  int          tick_cnt;

  request_t pending_items[$];
  result_t  expected_results[$];
  int       errors = 0;
  int       cycles = 0;
  int       sender_idle_pct = 0;
  logic [62:0] clock_now = '0;

  function automatic logic [63:0] add_saturating(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  // time until a deadline, zero once past, clipped to 63 bits
  function automatic logic [62:0] ns_until(logic [63:0] dl, logic [62:0] t);
    logic [63:0] d;
    if (dl <= {1'b0, t}) return '0;
    d = dl - {1'b0, t};
    return d[63] ? TOP63 : d[62:0];
  endfunction

  // pulls a timer out of the sorted queue; reports whether it was the head
  function automatic logic unlink_sorted(logic [3:0] id);
    for (int i = 0; i < sorted_cnt; i++) begin
      if (sorted_ids[i] == id) begin
        for (int j = i; j + 1 < sorted_cnt; j++) sorted_ids[j] = sorted_ids[j + 1];
        sorted_cnt--;
        return i == 0;
      end
    end
    return 1'b0;
  endfunction

  function automatic void unlink_tick(logic [3:0] id);
    for (int i = 0; i < tick_cnt; i++) begin
      if (tick_ids[i] == id) begin
        for (int j = i; j + 1 < tick_cnt; j++) tick_ids[j] = tick_ids[j + 1];
        tick_cnt--;
        return;
      end
    end
  endfunction

  // goes in front of any equal deadline
  function automatic void link_sorted(logic [3:0] id);
    int pos;
    pos = 0;
    if (sorted_cnt >= NT) return;
    while (pos < sorted_cnt && tmr_deadline[sorted_ids[pos]] < tmr_deadline[id]) pos++;
    for (int j = sorted_cnt; j > pos; j--) sorted_ids[j] = sorted_ids[j - 1];
    sorted_ids[pos] = id;
    sorted_cnt++;
  endfunction

  function automatic void device_reprogram(logic [62:0] t, ref result_t done);
    done.device_command = DEV_NONE;
    done.device_delay = '0;
    if (mdl_boot_cpu || tick_cnt != 0) return;
    if (sorted_cnt == 0) begin
      done.device_command = DEV_STOP;
    end else begin
      done.device_command = DEV_ONESHOT;
      done.device_delay = ns_until(tmr_deadline[sorted_ids[0]], t);
    end
  endfunction

  function automatic void push_fired(logic [3:0] id);
    result_t r;
    r = '0;
    r.fired_timer = id;
    expected_results.push_back(r);
  endfunction

  // Applies one item to the predictor and queues every result it causes.
  function automatic void predict_item(request_t rq);
    result_t     done;
    logic [3:0]  due [NT];
    int          n_due;
    logic        head_changed;
    logic [47:0] dur;
    logic        per;
    done = '0;
    done.result_kind = 1'b1;
    done.last = 1'b1;
    case (rq.op)
      OP_START: begin
        dur = rq.duration;
        per = rq.periodic;
        if (tmr_act[rq.timer_id]) begin
          if (tmr_tick[rq.timer_id]) unlink_tick(rq.timer_id);
          else void'(unlink_sorted(rq.timer_id));
        end
        if (rq.every_tick) begin
          dur = {16'd0, mdl_tick_ns};
          per = 1'b1;
        end
        tmr_deadline[rq.timer_id] = add_saturating({1'b0, rq.now}, {16'd0, dur});
        tmr_period[rq.timer_id] = dur;
        tmr_per[rq.timer_id] = per;
        tmr_tick[rq.timer_id] = rq.every_tick;
        tmr_act[rq.timer_id] = 1'b1;
        if (rq.every_tick) begin
          if (tick_cnt < NT) tick_ids[tick_cnt++] = rq.timer_id;
          if (!mdl_boot_cpu && tick_cnt == 1) done.device_command = DEV_PERIODIC;
        end else begin
          link_sorted(rq.timer_id);
          device_reprogram(rq.now, done);
        end
      end
      OP_STOP: begin
        head_changed = 1'b0;
        done.remaining = ns_until(tmr_deadline[rq.timer_id], rq.now);
        if (tmr_act[rq.timer_id]) begin
          if (tmr_tick[rq.timer_id]) begin
            unlink_tick(rq.timer_id);
            head_changed = 1'b1;
          end else begin
            head_changed = unlink_sorted(rq.timer_id);
          end
          tmr_act[rq.timer_id] = 1'b0;
        end
        if (head_changed) device_reprogram(rq.now, done);
      end
      OP_INT: begin
        for (int i = 0; i < tick_cnt; i++) push_fired(tick_ids[i]);
        n_due = 0;
        while (n_due < sorted_cnt && tmr_deadline[sorted_ids[n_due]] <= {1'b0, rq.now}) begin
          due[n_due] = sorted_ids[n_due];
          n_due++;
        end
        for (int i = n_due; i < sorted_cnt; i++) sorted_ids[i - n_due] = sorted_ids[i];
        sorted_cnt -= n_due;
        for (int i = 0; i < n_due; i++) push_fired(due[i]);
        // periodic timers go back only after the walk, so none fires twice
        for (int i = 0; i < n_due; i++) begin
          if (tmr_per[due[i]]) begin
            tmr_deadline[due[i]] = add_saturating({1'b0, rq.now}, {16'd0, tmr_period[due[i]]});
            link_sorted(due[i]);
          end else begin
            tmr_act[due[i]] = 1'b0;
          end
        end
        if (n_due > 0) device_reprogram(rq.now, done);
      end
      default: ;  // reserved op: plain completion, nothing changes
    endcase
    expected_results.push_back(done);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: start stays high across back-to-back items; one NBA per step.
  // --------------------------------------------------------------------------
  logic item_taken = 1'b0;

  always @(negedge clk) begin
    if (!rst && (!start || item_taken)) begin
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        request <= pending_items.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on acceptance, checks every strobed result.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    item_taken = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        item_taken = 1'b1;
        predict_item(request);
      end
      if (result_strobe) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: %p", result);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (result.result_kind !== want.result_kind) begin
            $error("result_kind exp %0d got %0d", want.result_kind, result.result_kind);
            errors++;
          end
          if (result.fired_timer !== want.fired_timer) begin
            $error("fired_timer exp %0d got %0d", want.fired_timer, result.fired_timer);
            errors++;
          end
          if (result.remaining !== want.remaining) begin
            $error("remaining exp %0d got %0d", want.remaining, result.remaining);
            errors++;
          end
          if (result.device_command !== want.device_command) begin
            $error("device_command exp %0d got %0d", want.device_command,
                   result.device_command);
            errors++;
          end
          if (result.device_delay !== want.device_delay) begin
            $error("device_delay exp %0d got %0d", want.device_delay, result.device_delay);
            errors++;
          end
          if (result.last !== want.last) begin
            $error("last exp %0d got %0d", want.last, result.last);
            errors++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic request_t mk(logic [1:0] op, logic [3:0] id, logic [47:0] dur,
                                  logic per, logic tick, logic [62:0] t);
    request_t r;
    r.op = op;
    r.timer_id = id;
    r.duration = dur;
    r.periodic = per;
    r.every_tick = tick;
    r.now = t;
    return r;
  endfunction

  // mostly a plausible timeline of starts/stops/interrupts, some wild values
  function automatic request_t random_item();
    request_t r;
    int pick;
    clock_now = clock_now + 63'($urandom_range(0, 3000));
    if ($urandom_range(0, 99) < 3) clock_now = 63'({$urandom, $urandom});
    r = mk(OP_START, 4'($urandom_range(0, NT - 1)), 48'($urandom_range(0, 6000)),
           1'($urandom), 1'($urandom_range(0, 99) < 12), clock_now);
    if ($urandom_range(0, 99) < 5) r.duration = 48'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 45)      r.op = OP_START;
    else if (pick < 65) r.op = OP_STOP;
    else if (pick < 96) r.op = OP_INT;
    else                r.op = OP_RSVD;
    return r;
  endfunction

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BOOT_CPU) mdl_boot_cpu = val[0];
    else mdl_tick_ns = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // block is idle once every item went in and every result came back
  task automatic drain();
    while (!(pending_items.size() == 0 && !start && expected_results.size() == 0))
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sequence of phases
  // --------------------------------------------------------------------------
  initial begin
    logic        boots   [5];
    logic [31:0] periods [5];
    int          idles   [5];

    boots = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    idles = '{0, 73, 0, 19, 50};
    periods = '{32'd1000000, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1000};
    periods[3] = $urandom_range(1, 5000);

    mdl_boot_cpu = 1'b0;
    mdl_tick_ns = 32'd1000000;
    sorted_cnt = 0;
    tick_cnt = 0;
    for (int i = 0; i < NT; i++) begin
      tmr_deadline[i] = '0;
      tmr_period[i] = '0;
      tmr_per[i] = 1'b0;
      tmr_tick[i] = 1'b0;
      tmr_act[i] = 1'b0;
      sorted_ids[i] = '0;
      tick_ids[i] = '0;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset register values first
    pending_items.push_back(mk(OP_START, 4'd0, 48'd0, 1'b0, 1'b0, 63'd0));   // due at once
    pending_items.push_back(mk(OP_INT, 4'd0, 48'd0, 1'b0, 1'b0, 63'd0));     // fires 0
    pending_items.push_back(mk(OP_INT, 4'd0, 48'd0, 1'b0, 1'b0, 63'd5));     // nothing due
    pending_items.push_back(mk(OP_START, 4'd3, 48'd100, 1'b1, 1'b0, 63'd10));
    pending_items.push_back(mk(OP_START, 4'd4, 48'd100, 1'b0, 1'b0, 63'd10)); // tie: ahead of 3
    pending_items.push_back(mk(OP_START, 4'd5, 48'd300, 1'b0, 1'b0, 63'd10));
    pending_items.push_back(mk(OP_STOP, 4'd5, 48'd0, 1'b0, 1'b0, 63'd20));   // not head
    pending_items.push_back(mk(OP_STOP, 4'd5, 48'd0, 1'b0, 1'b0, 63'd20));   // already inactive
    pending_items.push_back(mk(OP_START, 4'd3, 48'd50, 1'b0, 1'b0, 63'd20)); // restart, now head
    pending_items.push_back(mk(OP_START, 4'd7, 48'd9, 1'b0, 1'b1, 63'd20));  // tick list, periodic dev
    pending_items.push_back(mk(OP_START, 4'd8, 48'd9, 1'b0, 1'b1, 63'd20));  // second tick timer
    pending_items.push_back(mk(OP_INT, 4'd0, 48'd0, 1'b0, 1'b0, 63'd200));   // ticks, then 3 and 4
    pending_items.push_back(mk(OP_STOP, 4'd7, 48'd0, 1'b0, 1'b0, 63'd210));  // tick list stop
    pending_items.push_back(mk(OP_STOP, 4'd8, 48'd0, 1'b0, 1'b0, 63'd210));  // list empty
    pending_items.push_back(mk(OP_START, 4'd15, {48{1'b1}}, 1'b1, 1'b0, TOP63));
    pending_items.push_back(mk(OP_STOP, 4'd15, 48'd0, 1'b0, 1'b0, 63'd0));   // clipped remaining
    pending_items.push_back(mk(OP_START, 4'd15, 48'd1, 1'b1, 1'b0, TOP63 - 63'd1));
    pending_items.push_back(mk(OP_INT, 4'd0, 48'd0, 1'b0, 1'b0, TOP63));     // periodic re-queue
    pending_items.push_back(mk(OP_START, 4'd12, 48'd5, 1'b0, 1'b0, 63'd1000));
    pending_items.push_back(mk(OP_STOP, 4'd12, 48'd0, 1'b0, 1'b0, 63'd1000)); // head stop
    pending_items.push_back(mk(OP_RSVD, 4'd15, {48{1'b1}}, 1'b1, 1'b1, TOP63));
    pending_items.push_back(mk(OP_STOP, 4'd15, 48'd0, 1'b0, 1'b0, 63'd2000)); // empties queue
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_BOOT_CPU, {31'd0, boots[ph]});
      write_reg(REG_TICK_PERIOD, periods[ph]);
      sender_idle_pct = idles[ph];
      for (int k = 0; k < 60; k++) pending_items.push_back(random_item());
      drain();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: deadline_sorted_timer_queue_top.f
design/dstq_pkg.sv
design/dstq_ram.sv
design/dstq_front.sv
design/dstq_back.sv
design/deadline_sorted_timer_queue_top.sv
tb/deadline_sorted_timer_queue_top_tb.sv
